// ===== hw/rtl/cag_pkg.sv =====
// Shared types and codes of the 6502 effective-address unit.
// Used by cag_step and cpu6502_address_generator_top; no dependencies.
package cag_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 64;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_OPLO  = 6'b000010,
    PH_OPHI  = 6'b000100,
    PH_PTRLO = 6'b001000,
    PH_PTRHI = 6'b010000,
    PH_VALUE = 6'b100000
  } phase_e;

  typedef enum logic [3:0] {
    M_IMPL = 4'd0,
    M_IMM  = 4'd1,
    M_ABS  = 4'd2,
    M_ZP   = 4'd3,
    M_ABSX = 4'd4,
    M_ABSY = 4'd5,
    M_ZPX  = 4'd6,
    M_ZPY  = 4'd7,
    M_IND  = 4'd8,
    M_INDX = 4'd9,
    M_INDY = 4'd10,
    M_REL  = 4'd11,
    M_OPC  = 4'd12,
    M_VAL  = 4'd13
  } mode_e;

  typedef enum logic [1:0] {
    K_READ    = 2'd0,
    K_DONE    = 2'd1,
    K_IGNORED = 2'd2
  } kind_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_DATA  = 1'b1
  } req_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  active_mode;
    logic [15:0] prog_counter;
    logic [15:0] eff_addr;
    logic [15:0] pointer_addr;
    logic [7:0]  low_byte;
    logic [7:0]  x_latched;
    logic [7:0]  y_latched;
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  mode;
    logic [15:0] pc_in;
    logic [7:0]  x_index;
    logic [7:0]  y_index;
    logic [7:0]  read_data;
  } item_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [15:0] read_address;
    logic [15:0] effective_address;
    logic [15:0] next_pc;
    logic        page_crossed;
    logic [7:0]  fetched_byte;
  } result_t;

endpackage

// ===== hw/rtl/cag_step.sv =====
// One step of the addressing sequencer: current state and one item in,
// next state and one result out. Combinational; depends on cag_pkg.
module cag_step (
  input  cag_pkg::state_t  st_i,
  input  cag_pkg::item_t   item_i,
  output cag_pkg::state_t  st_o,
  output cag_pkg::result_t res_o
);
  import cag_pkg::*;

  logic        done;
  logic        ignored;
  logic        crossed;
  logic [7:0]  byte_out;
  logic [15:0] rd_addr;
  logic [15:0] word;
  logic [7:0]  idx;
  logic [8:0]  low_sum;
  logic [7:0]  d;

  always_comb begin
    st_o     = st_i;
    done     = 1'b0;
    ignored  = 1'b0;
    crossed  = 1'b0;
    byte_out = 8'h00;
    rd_addr  = 16'h0000;
    d        = item_i.read_data;
    word     = {d, st_i.low_byte};
    idx      = (mode_e'(st_i.active_mode) == M_ABSX) ? st_i.x_latched : st_i.y_latched;
    low_sum  = {1'b0, word[7:0]} + {1'b0, idx};

    if (req_e'(item_i.req_type) == REQ_START) begin
      st_o.active_mode  = item_i.mode;
      st_o.prog_counter = item_i.pc_in;
      st_o.x_latched    = item_i.x_index;
      st_o.y_latched    = item_i.y_index;
      unique case (mode_e'(item_i.mode))
        M_IMM: begin
          st_o.eff_addr     = item_i.pc_in;
          st_o.prog_counter = item_i.pc_in + 16'd1;
          done              = 1'b1;
        end
        M_OPC: begin
          st_o.phase = PH_VALUE;
          rd_addr    = item_i.pc_in;
        end
        M_VAL: begin
          st_o.phase = PH_VALUE;
          rd_addr    = st_i.eff_addr;
        end
        M_ABS, M_ZP, M_ABSX, M_ABSY, M_ZPX, M_ZPY, M_IND, M_INDX, M_INDY, M_REL: begin
          st_o.phase = PH_OPLO;
          rd_addr    = item_i.pc_in;
        end
        default: done = 1'b1;
      endcase
    end else begin
      unique case (st_i.phase)
        PH_OPLO: begin
          st_o.low_byte     = d;
          st_o.prog_counter = st_i.prog_counter + 16'd1;
          unique case (mode_e'(st_i.active_mode))
            M_ZP: begin
              st_o.eff_addr = {8'h00, d};
              done          = 1'b1;
            end
            M_ZPX: begin
              st_o.eff_addr = {8'h00, d + st_i.x_latched};
              done          = 1'b1;
            end
            M_ZPY: begin
              st_o.eff_addr = {8'h00, d + st_i.y_latched};
              done          = 1'b1;
            end
            M_INDX: begin
              st_o.pointer_addr = {8'h00, d + st_i.x_latched};
              st_o.phase        = PH_PTRLO;
              rd_addr           = st_o.pointer_addr;
            end
            M_INDY: begin
              st_o.pointer_addr = {8'h00, d};
              st_o.phase        = PH_PTRLO;
              rd_addr           = st_o.pointer_addr;
            end
            M_REL: begin
              // Branch target: PC past the offset plus the sign-extended offset.
              st_o.eff_addr = st_o.prog_counter + {{8{d[7]}}, d};
              done          = 1'b1;
            end
            default: begin
              st_o.phase = PH_OPHI;
              rd_addr    = st_o.prog_counter;
            end
          endcase
        end
        PH_OPHI: begin
          st_o.prog_counter = st_i.prog_counter + 16'd1;
          unique case (mode_e'(st_i.active_mode))
            M_ABSX, M_ABSY: begin
              st_o.eff_addr = word + {8'h00, idx};
              crossed       = low_sum[8];
              done          = 1'b1;
            end
            M_IND: begin
              st_o.pointer_addr = word;
              st_o.phase        = PH_PTRLO;
              rd_addr           = word;
            end
            default: begin
              st_o.eff_addr = word;
              done          = 1'b1;
            end
          endcase
        end
        PH_PTRLO: begin
          st_o.low_byte = d;
          st_o.phase    = PH_PTRHI;
          // Zero-page pointers wrap inside page zero; the indirect jump does not.
          if (mode_e'(st_i.active_mode) == M_IND) begin
            rd_addr = st_i.pointer_addr + 16'd1;
          end else begin
            rd_addr = {8'h00, st_i.pointer_addr[7:0] + 8'd1};
          end
        end
        PH_PTRHI: begin
          if (mode_e'(st_i.active_mode) == M_INDY) begin
            st_o.eff_addr = word + {8'h00, st_i.y_latched};
            crossed       = low_sum[8];
          end else begin
            st_o.eff_addr = word;
          end
          done = 1'b1;
        end
        PH_VALUE: begin
          if (mode_e'(st_i.active_mode) == M_OPC) begin
            st_o.prog_counter = st_i.prog_counter + 16'd1;
          end
          byte_out = d;
          done     = 1'b1;
        end
        default: ignored = 1'b1;
      endcase
    end

    if (done) begin
      st_o.phase = PH_IDLE;
    end

    res_o = '0;
    priority if (ignored) begin
      res_o.result_kind = K_IGNORED;
    end else if (done) begin
      res_o.result_kind       = K_DONE;
      res_o.effective_address = st_o.eff_addr;
      res_o.next_pc           = st_o.prog_counter;
      res_o.page_crossed      = crossed;
      res_o.fetched_byte      = byte_out;
    end else begin
      res_o.result_kind  = K_READ;
      res_o.read_address = rd_addr;
    end
  end

endmodule

// ===== hw/rtl/cpu6502_address_generator_top.sv =====
// Top level of the 6502 effective-address unit: input register, sequencer
// state, result register and stream ports. Depends on cag_pkg and cag_step.
//
//  channel  | dir | tdata                                  | tuser
//  ---------+-----+----------------------------------------+-------------
//  s_axis   | in  | mode, pc_in, x_index, y_index, read_data | req_type
//  m_axis   | out | read_address, effective_address,         | result_kind
//           |     | next_pc, page_crossed, fetched_byte      |
//
// Every transaction in gives exactly one transaction out, one per clock while
// m_axis accepts. Each item passes the input register, then the step logic
// into the result register; the sequencer state updates as the item leaves
// the input register. Reset (rst_ni low) empties both registers and puts the
// sequencer in idle with all addresses zero. A stall on m_axis holds the
// result; one more item waits in the input register before s_axis stalls.
module cpu6502_address_generator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [3:0] mode, [19:4] pc_in, [27:20] x_index, [35:28] y_index,
  // [43:36] read_data, [47:44] zero
  input  logic [cag_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] req_type
  input  logic [0:0]                   s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [15:0] read_address, [31:16] effective_address, [47:32] next_pc,
  // [48] page_crossed, [56:49] fetched_byte, [63:57] zero
  output logic [cag_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [1:0] result_kind
  output logic [1:0]                   m_axis_tuser_o
);
  import cag_pkg::*;

  // Input register.
  logic    in_valid_q;
  item_t   in_item_q;
  item_t   in_item_d;

  // Sequencer state.
  state_t  st_q;
  state_t  st_d;

  // Result register.
  logic    out_valid_q;
  result_t out_res_q;
  result_t step_res;

  logic    advance;
  logic    s_fire;

  // Advance the input item whenever the result register is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_item_d.req_type  = s_axis_tuser_i[0];
    in_item_d.mode      = s_axis_tdata_i[3:0];
    in_item_d.pc_in     = s_axis_tdata_i[19:4];
    in_item_d.x_index   = s_axis_tdata_i[27:20];
    in_item_d.y_index   = s_axis_tdata_i[35:28];
    in_item_d.read_data = s_axis_tdata_i[43:36];
  end

  cag_step u_step (
    .st_i   (st_q),
    .item_i (in_item_q),
    .st_o   (st_d),
    .res_o  (step_res)
  );

  // Valid flags and sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on transaction, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.result_kind;
  assign m_axis_tdata_o  = {7'b0000000,
                            out_res_q.fetched_byte,
                            out_res_q.page_crossed,
                            out_res_q.next_pc,
                            out_res_q.effective_address,
                            out_res_q.read_address};

`ifndef ASSERT_OFF
  // A finished sequence always leaves the sequencer idle.
  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (step_res.result_kind == K_DONE) |=> st_q.phase == PH_IDLE)
    else $error("sequencer not idle after done result");

  // A read request always leaves a sequence waiting for its byte.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (step_res.result_kind == K_READ) |=> st_q.phase != PH_IDLE)
    else $error("read request issued but sequencer idle");

  // A stalled result is never dropped or overwritten.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_res_q))
    else $error("stalled result lost");

  // Page crossing is reported only with a done result.
  a_cross_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.result_kind != K_DONE) |-> !out_res_q.page_crossed)
    else $error("page_crossed set outside done result");
`endif

endmodule

// ===== verif/cpu6502_address_generator_top_tb.sv =====
// Self-checking testbench for the 6502 effective-address unit: directed table, then
// random mode sequences, each result checked against a fixed value or a cycle-free address predictor.
// Depends on cag_pkg and cpu6502_address_generator_top.
module cpu6502_address_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cag_pkg::*;

  localparam int unsigned RandWork  = 1900;
  localparam int unsigned DirRows   = 29;
  localparam int unsigned IdlePct   = 32;
  localparam logic [3:0]  MODE_SPARE = 4'd15;

  typedef struct packed {
    logic    fixed_exp;
    item_t   it;
    result_t res;
  } dir_row_t;

  localparam result_t NO_RES = '0;

  // Directed stimulus. Rows with fixed_exp set carry their own expected result;
  // the rest are predicted.
  localparam dir_row_t DIR_TAB [DirRows] = '{
    // data while idle after reset
    '{1'b1, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'h5A},
            '{K_IGNORED, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00}},
    // value fetch reads the held address, zero after reset
    '{1'b1, '{REQ_START, M_VAL, 16'h1234, 8'h00, 8'h00, 8'h00},
            '{K_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00}},
    '{1'b1, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hFF},
            '{K_DONE, 16'h0000, 16'h0000, 16'h1234, 1'b0, 8'hFF}},
    '{1'b1, '{REQ_START, M_IMPL, 16'hFFFF, 8'hFF, 8'hFF, 8'h00},
            '{K_DONE, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 8'h00}},
    // immediate at the top of memory wraps the next PC
    '{1'b1, '{REQ_START, M_IMM, 16'hFFFF, 8'h00, 8'h00, 8'h00},
            '{K_DONE, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 8'h00}},
    // unused mode code behaves as implied
    '{1'b1, '{REQ_START, MODE_SPARE, 16'h0000, 8'h00, 8'h00, 8'h00},
            '{K_DONE, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 8'h00}},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'hFFFF, 8'hFF, 8'hFF, 8'h00}, NO_RES},
    // absolute X with operand fetch wrapping past 0xFFFF and a page cross
    '{1'b0, '{REQ_START, M_ABSX, 16'hFFFE, 8'hFF, 8'h00, 8'h00}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hFF}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hFF}, NO_RES},
    // zero page X wraps within page zero
    '{1'b0, '{REQ_START, M_ZPX, 16'h8000, 8'hFF, 8'h00, 8'h00}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hFF}, NO_RES},
    // indirect indexed: pointer at 0xFF wraps to 0x00, Y carries
    '{1'b0, '{REQ_START, M_INDY, 16'h00FF, 8'h00, 8'h01, 8'h00}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hFF}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hFF}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hFF}, NO_RES},
    // indirect through 0xFFFF: high byte comes from 0x0000
    '{1'b0, '{REQ_START, M_IND, 16'h4000, 8'h00, 8'h00, 8'h00}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hFF}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hFF}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'h34}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'h12}, NO_RES},
    // relative with the most negative offset
    '{1'b0, '{REQ_START, M_REL, 16'h0000, 8'h00, 8'h00, 8'h00}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'h80}, NO_RES},
    '{1'b0, '{REQ_START, M_OPC, 16'h7FFF, 8'h00, 8'h00, 8'h00}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'hA5}, NO_RES},
    // absolute abandoned halfway by a new start
    '{1'b0, '{REQ_START, M_ABS, 16'h0100, 8'h00, 8'h00, 8'h00}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'h00}, NO_RES},
    '{1'b0, '{REQ_START, M_ZP, 16'h0200, 8'h00, 8'h00, 8'h00}, NO_RES},
    '{1'b0, '{REQ_DATA, M_IMPL, 16'h0000, 8'h00, 8'h00, 8'h80}, NO_RES}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic [0:0]          s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;

  // predictor state
  phase_e      ph;
  logic [3:0]  md;
  logic [15:0] pc;
  logic [15:0] ea;
  logic [15:0] ptr;
  logic [7:0]  lo;
  logic [7:0]  xr;
  logic [7:0]  yr;

  result_t     awaited_results [$];
  int          fail_count = 0;
  int          work_items = 0;
  logic        calm = 1'b0;

  cpu6502_address_generator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t read_req(input logic [15:0] addr);
    result_t r;
    r = '0;
    r.result_kind  = K_READ;
    r.read_address = addr;
    return r;
  endfunction

  function automatic result_t seq_done(input logic crossed, input logic [7:0] val);
    result_t r;
    r = '0;
    ph = PH_IDLE;
    r.result_kind       = K_DONE;
    r.effective_address = ea;
    r.next_pc           = pc;
    r.page_crossed      = crossed;
    r.fetched_byte      = val;
    return r;
  endfunction

  // Index a 16-bit base, leave the sum in ea and return the low-byte carry.
  function automatic logic index_base(input logic [15:0] base, input logic [7:0] idx);
    logic [8:0] low_sum;
    low_sum = {1'b0, base[7:0]} + {1'b0, idx};
    ea = base + {8'h00, idx};
    return low_sum[8];
  endfunction

  function automatic result_t predict_address_step(input item_t it);
    result_t     r;
    logic [15:0] addr;
    logic [7:0]  d;
    logic [7:0]  zsum;
    r = '0;
    r.result_kind = K_IGNORED;
    d = it.read_data;
    if (it.req_type == REQ_START) begin
      md = it.mode;
      pc = it.pc_in;
      xr = it.x_index;
      yr = it.y_index;
      if (md == M_IMM) begin
        ea = pc;
        pc = pc + 16'd1;
        r = seq_done(1'b0, 8'h00);
      end else if (md == M_OPC) begin
        ph = PH_VALUE;
        r = read_req(pc);
      end else if (md == M_VAL) begin
        ph = PH_VALUE;
        r = read_req(ea);
      end else if (md >= M_ABS && md <= M_REL) begin
        ph = PH_OPLO;
        r = read_req(pc);
      end else begin
        r = seq_done(1'b0, 8'h00);
      end
      return r;
    end
    case (ph)
      PH_OPLO: begin
        lo = d;
        pc = pc + 16'd1;
        case (md)
          M_ZP: begin
            ea = {8'h00, d};
            r = seq_done(1'b0, 8'h00);
          end
          M_ZPX, M_ZPY: begin
            zsum = d + ((md == M_ZPX) ? xr : yr);
            ea = {8'h00, zsum};
            r = seq_done(1'b0, 8'h00);
          end
          M_INDX, M_INDY: begin
            zsum = (md == M_INDX) ? d + xr : d;
            ptr = {8'h00, zsum};
            ph = PH_PTRLO;
            r = read_req(ptr);
          end
          M_REL: begin
            ea = pc + {{8{d[7]}}, d};
            r = seq_done(1'b0, 8'h00);
          end
          default: begin
            ph = PH_OPHI;
            r = read_req(pc);
          end
        endcase
      end
      PH_OPHI: begin
        addr = {d, lo};
        pc = pc + 16'd1;
        if (md == M_ABSX) begin
          r = seq_done(index_base(addr, xr), 8'h00);
        end else if (md == M_ABSY) begin
          r = seq_done(index_base(addr, yr), 8'h00);
        end else if (md == M_IND) begin
          ptr = addr;
          ph = PH_PTRLO;
          r = read_req(ptr);
        end else begin
          ea = addr;
          r = seq_done(1'b0, 8'h00);
        end
      end
      PH_PTRLO: begin
        lo = d;
        ph = PH_PTRHI;
        // plain indirect crosses pages; zero-page pointers stay in page zero
        if (md == M_IND) r = read_req(ptr + 16'd1);
        else r = read_req({8'h00, ptr[7:0] + 8'd1});
      end
      PH_PTRHI: begin
        addr = {d, lo};
        if (md == M_INDY) begin
          r = seq_done(index_base(addr, yr), 8'h00);
        end else begin
          ea = addr;
          r = seq_done(1'b0, 8'h00);
        end
      end
      PH_VALUE: begin
        if (md == M_OPC) pc = pc + 16'd1;
        r = seq_done(1'b0, d);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one transaction after an optional random gap; predict once accepted.
  task automatic send_item(input item_t it, input logic fixed_exp, input result_t fixed_res);
    result_t r;
    if (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'h0, it.read_data, it.y_index, it.x_index, it.pc_in, it.mode};
    s_axis_tuser_i  <= it.req_type;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = predict_address_step(it);
    if (r.result_kind != K_IGNORED) work_items++;
    awaited_results.push_back(fixed_exp ? fixed_res : r);
  endtask

  // Hold the sender until every expected result has drained.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  function automatic item_t rand_item(input logic req);
    item_t it;
    it.req_type  = req;
    it.mode      = 4'($urandom_range(15));
    it.pc_in     = ($urandom_range(7) == 0) ? 16'hFFFF - 16'($urandom_range(2))
                                            : 16'($urandom);
    it.x_index   = 8'($urandom);
    it.y_index   = 8'($urandom);
    it.read_data = 8'($urandom);
    return it;
  endfunction

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready_i <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Result checker: compare every accepted transaction with the oldest expectation.
  task automatic compare_field(input string fname, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", fname, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result with no expectation: kind %0d data %h", m_axis_tuser_o, m_axis_tdata_o);
        fail_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        compare_field("result_kind", 16'(exp_r.result_kind), 16'(m_axis_tuser_o));
        compare_field("read_address", exp_r.read_address, m_axis_tdata_o[15:0]);
        compare_field("effective_address", exp_r.effective_address, m_axis_tdata_o[31:16]);
        compare_field("next_pc", exp_r.next_pc, m_axis_tdata_o[47:32]);
        compare_field("page_crossed", 16'(exp_r.page_crossed), 16'(m_axis_tdata_o[48]));
        compare_field("fetched_byte", 16'(exp_r.fetched_byte), 16'(m_axis_tdata_o[56:49]));
      end
    end
  end

  initial begin
    logic  drained_mid;
    drained_mid     = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_START;
    ph = PH_IDLE;
    md = '0;
    pc = '0;
    ea = '0;
    ptr = '0;
    lo = '0;
    xr = '0;
    yr = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      send_item(DIR_TAB[i].it, DIR_TAB[i].fixed_exp, DIR_TAB[i].res);
    end
    drain_results();

    work_items = 0;
    while (work_items < RandWork) begin
      calm = (work_items >= 900 && work_items < 1200);
      if (!drained_mid && work_items >= 1500) begin
        drained_mid = 1'b1;
        drain_results();
      end
      // stray byte, ignored when nothing is in flight
      if ($urandom_range(9) == 0) send_item(rand_item(REQ_DATA), 1'b0, NO_RES);
      send_item(rand_item(REQ_START), 1'b0, NO_RES);
      while (ph != PH_IDLE) begin
        // cut the sequence short now and then; the next start abandons it
        if ($urandom_range(15) == 0) break;
        send_item(rand_item(REQ_DATA), 1'b0, NO_RES);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
